/* rtl/oaht_pkg.sv */
package oaht_pkg;

    localparam int DEPTH_DEF          = 1024;
    localparam int RECORD_BITS_DEF    = 32;
    localparam int KEY_BITS           = 32;
    localparam int DATA_BITS          = 32;
    localparam int SLOT_BITS          = 10;
    localparam int SIZE_BITS          = 11;
    localparam int SIZE_RST           = 1024;
    localparam logic [KEY_BITS-1:0] KEY_HASH_MASK = 32'h7FFF_FFFF;
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = KEY_BITS / DIV_BITS_PER_CYCLE;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                     opcode;
        logic signed [KEY_BITS-1:0]  key;
        logic        [DATA_BITS-1:0] record_data;
    } t_in_word;

    typedef struct packed {
        t_status                     status;
        logic        [SLOT_BITS-1:0] slot;
        logic        [DATA_BITS-1:0] found_data;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

/* rtl/oaht_ram.sv */
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/open_address_hash_table_top.sv */
// An insert into a full table skips the modulo and the probes and goes to the output register;
// otherwise the home-slot modulo is worked out 4 bits per cycle, slots are probed one per
// cycle on the single RAM read port, and the result then goes to the output register.
// Words are stalled while one is in work; the next word is taken while a result waits.
// Reset: synchronous, active low; a clearing pass over all DEPTH slots (1024 by default)
// empties the table, words are stalled meanwhile, config writes are taken.
module open_address_hash_table_top
    import oaht_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIZE_BITS-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_word             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_word            o_data
);

    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = $clog2(DEPTH + 1);
    localparam int W       = 1 + KEY_BITS + RECORD_BITS;
    localparam int CB      = (RECORD_BITS < DATA_BITS) ? RECORD_BITS : DATA_BITS;
    localparam int SZ_RST  = (SIZE_RST > DEPTH) ? DEPTH : SIZE_RST;
    localparam int CW      = $clog2(DIV_CYCLES);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_p, n_p;
    logic [SW-1:0]        r_i, n_i;
    logic [SW-1:0]        r_rem, n_rem;
    logic [KEY_BITS-1:0]  r_dvd, n_dvd;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [SW-1:0]        r_count, n_count;
    logic [SW-1:0]        r_size, n_size;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_out, n_out;
    t_out_word            r_res, n_res;
    t_opcode              r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_rec;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [W-1:0]         ram_wdata, ram_rdata;

    logic                 in_acc;
    logic                 rd_occ;
    logic [KEY_BITS-1:0]  rd_key;
    logic [RECORD_BITS-1:0] rec_store;
    logic [AW-1:0]        p_next;
    logic                 last_probe;
    logic [SW:0]          rem_w;
    logic [SW-1:0]        rem_t;
    logic [KEY_BITS-1:0]  dvd_t;

    function automatic t_out_word mk_res(t_status s, logic [SLOT_BITS-1:0] sl,
                                         logic [DATA_BITS-1:0] d);
        t_out_word r;
        r.status     = s;
        r.slot       = sl;
        r.found_data = d;
        return r;
    endfunction

    oaht_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc     = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_data     = r_out;
    assign rd_occ     = ram_rdata[W-1];
    assign rd_key     = ram_rdata[W-2 -: KEY_BITS];
    assign rec_store  = RECORD_BITS'(r_rec[CB-1:0]);
    assign p_next     = ((SW'(r_p) + SW'(1)) == r_size) ? '0 : r_p + AW'(1);
    assign last_probe = (r_i == (r_size - SW'(1)));

    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = SW'(1);
        end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
            n_size = SW'(DEPTH);
        end else begin
            n_size = SW'(i_cfg_data);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_p       = r_p;
        n_i       = r_i;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_res     = r_res;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        ram_we    = 1'b0;
        ram_waddr = r_p;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_p;
        rem_w     = '0;
        rem_t     = r_rem;
        dvd_t     = r_dvd;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_p    = r_p + AW'(1);
                if (r_p == AW'(DEPTH - 1)) begin
                    n_p     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.opcode == OP_INSERT && r_count >= r_size) begin
                        n_res   = mk_res(ST_FULL, '0, '0);
                        n_state = S_DONE;
                    end else begin
                        n_rem   = '0;
                        n_dvd   = i_data.key & KEY_HASH_MASK;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                for (int b = 0; b < DIV_BITS_PER_CYCLE; b++) begin
                    rem_w = {rem_t, dvd_t[KEY_BITS-1]};
                    if (rem_w >= {1'b0, r_size}) begin
                        rem_w = rem_w - {1'b0, r_size};
                    end
                    rem_t = rem_w[SW-1:0];
                    dvd_t = {dvd_t[KEY_BITS-2:0], 1'b0};
                end
                n_rem = rem_t;
                n_dvd = dvd_t;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_CYCLES - 1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(rem_t);
                    n_p       = AW'(rem_t);
                    n_i       = '0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_op == OP_INSERT) begin
                    priority if (!rd_occ) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_key, rec_store};
                        n_count   = r_count + SW'(1);
                        n_res     = mk_res(ST_OK, SLOT_BITS'(r_p), '0);
                        n_state   = S_DONE;
                    end else if (last_probe) begin
                        n_res   = mk_res(ST_FULL, '0, '0);
                        n_state = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = p_next;
                        n_p       = p_next;
                        n_i       = r_i + SW'(1);
                    end
                end else begin
                    priority if (!rd_occ) begin
                        n_res   = mk_res(ST_NOT_FOUND, '0, '0);
                        n_state = S_DONE;
                    end else if (rd_key == r_key) begin
                        n_res   = mk_res(ST_OK, SLOT_BITS'(r_p),
                                         DATA_BITS'(ram_rdata[CB-1:0]));
                        n_state = S_DONE;
                    end else if (last_probe) begin
                        n_res   = mk_res(ST_NOT_FOUND, '0, '0);
                        n_state = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = p_next;
                        n_p       = p_next;
                        n_i       = r_i + SW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_p      <= '0;
            r_i      <= '0;
            r_cnt    <= '0;
            r_count  <= '0;
            r_size   <= SW'(SZ_RST);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p      <= n_p;
            r_i      <= n_i;
            r_cnt    <= n_cnt;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_size <= n_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_res <= n_res;
        r_out <= n_out;
        if (in_acc) begin
            r_op  <= i_data.opcode;
            r_key <= i_data.key;
            r_rec <= i_data.record_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(DEPTH))
        else $error("entry count beyond table depth");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_i < r_size))
        else $error("probe walk longer than table size");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_PROBE))
        else $error("table write outside clear or probe");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_OK) |-> (o_data.slot == '0 && o_data.found_data == '0))
        else $error("failed result carries slot or data");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DIV || r_state == S_DONE))
        else $error("accepted word not started");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import oaht_pkg::*;

    localparam int SLOTS     = DEPTH_DEF;
    localparam int LIMIT     = 6_000_000;
    localparam int HOLD_LEN  = 400;
    localparam int N_PHASES  = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SIZE_BITS-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    t_in_word             i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_out_word            o_data;

    // table shadow
    logic                 slot_used [SLOTS];
    logic [KEY_BITS-1:0]  slot_key  [SLOTS];
    logic [DATA_BITS-1:0] slot_data [SLOTS];
    int unsigned          live_entries;
    logic [SIZE_BITS-1:0] size_reg;
    logic [KEY_BITS-1:0]  stored_keys [$];

    t_out_word            expected_words [$];
    int                   errors;
    bit                   quiet;
    bit                   hold_req;

    open_address_hash_table_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("FAIL open_address_hash_table_top");
        $finish;
    end

    function automatic t_out_word probe_table(t_in_word w);
        int unsigned          sz;
        int unsigned          home;
        int unsigned          p;
        logic [KEY_BITS-1:0]  k;
        t_out_word            r;
        k            = w.key;
        r.slot       = '0;
        r.found_data = '0;
        sz = size_reg;
        if (sz < 1) sz = 1;
        if (sz > SLOTS) sz = SLOTS;
        home = (k & KEY_HASH_MASK) % sz;
        if (w.opcode == OP_INSERT) begin
            r.status = ST_FULL;
            if (live_entries >= sz) return r;
            for (int i = 0; i < sz; i++) begin
                p = (home + i) % sz;
                if (!slot_used[p]) begin
                    slot_used[p] = 1'b1;
                    slot_key[p]  = k;
                    slot_data[p] = w.record_data;
                    live_entries++;
                    stored_keys.push_back(k);
                    r.status = ST_OK;
                    r.slot   = p[SLOT_BITS-1:0];
                    return r;
                end
            end
            return r;
        end
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < sz; i++) begin
            p = (home + i) % sz;
            if (!slot_used[p]) break;
            if (slot_key[p] == k) begin
                r.status     = ST_OK;
                r.slot       = p[SLOT_BITS-1:0];
                r.found_data = slot_data[p];
                return r;
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (stored_keys.size() == 0) k = $urandom();
                else k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: k = 32'h0000_0000;
                    1: k = 32'h7FFF_FFFF;
                    2: k = 32'h8000_0000;
                    default: k = 32'hFFFF_FFFF;
                endcase
            end
            5: k = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 2047))};
            default: k = $urandom();
        endcase
        return k;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (errors < 40)
            $display("mismatch %s: got %0h expected %0h", field, got, want);
        errors++;
    endtask

    task automatic send_word(t_opcode op, logic [KEY_BITS-1:0] k, logic [DATA_BITS-1:0] d);
        t_in_word w;
        int       g;
        w.opcode      = op;
        w.key         = k;
        w.record_data = d;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        expected_words.push_back(probe_table(w));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_BITS-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_reg    = v;
    endtask

    // receiver side
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_LEN; n++) @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(12, 60)
                                                    : $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_data.status), 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (o_data.status !== want.status)
                    report_mismatch("status", 32'(o_data.status), 32'(want.status));
                if (o_data.slot !== want.slot)
                    report_mismatch("slot", 32'(o_data.slot), 32'(want.slot));
                if (o_data.found_data !== want.found_data)
                    report_mismatch("found_data", o_data.found_data, want.found_data);
            end
        end
    end

    task automatic check_insert_search();
        write_size(11'd1024);
        send_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_word(OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_SEARCH, 32'h0000_0005, 32'h0000_0000);
        send_word(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_word(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic check_size_limits();
        write_size(11'd4);
        send_word(OP_INSERT, 32'h0000_0009, 32'hFFFF_FFFF);
        send_word(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_SEARCH, 32'h0000_0007, 32'h0000_0000);
        write_size(11'd0);
        send_word(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_INSERT, 32'h0000_0001, 32'h0000_0001);
        write_size(11'd2047);
        send_word(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(OP_INSERT, 32'h0000_03FF, 32'hCAFE_F00D);
        send_word(OP_SEARCH, 32'h0000_03FF, 32'h0000_0000);
    endtask

    task automatic run_random_phases();
        int sizes    [N_PHASES] = '{16, 8, 64, 1, 0, 200, 1024, 100, 2047, 1023};
        int lengths  [N_PHASES] = '{60, 40, 100, 20, 20, 150, 300, 80, 300, 150};
        int ins_pct  [N_PHASES] = '{60, 30, 50, 50, 50, 50, 45, 30, 40, 40};
        t_opcode op;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_size(sizes[ph][SIZE_BITS-1:0]);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < lengths[ph]; n++) begin
                op = ($urandom_range(0, 99) < ins_pct[ph]) ? OP_INSERT : OP_SEARCH;
                send_word(op, pick_key(), $urandom());
            end
        end
        quiet = 1'b0;
    endtask

    task automatic check_output_backpressure();
        t_opcode op;
        write_size(11'd1024);
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 150; n++) begin
            op = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_SEARCH;
            send_word(op, pick_key(), $urandom());
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        errors       = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        live_entries = 0;
        size_reg     = 11'(SIZE_RST);
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        @(posedge i_clk);

        check_insert_search();
        check_size_limits();
        run_random_phases();
        check_output_backpressure();

        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS open_address_hash_table_top");
        end else begin
            $display("FAIL open_address_hash_table_top");
        end
        $finish;
    end

endmodule
